// File: rtl/pcsg_pkg.sv
// ----------------------------------------------------------------------------
// pcsg_pkg
// Shared types, constants and a helper function for the Peano curve segment
// generator: register map, heading encoding and the segment color table.
// ----------------------------------------------------------------------------
package pcsg_pkg;

    // Default values for the top level parameters
    localparam int MAX_LEVELS_DEF = 7;
    localparam int COORD_BITS_DEF = 12;

    // Register port geometry
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Register field widths
    localparam int LEVELS_W   = 3;
    localparam int STEP_W     = 11;
    localparam int CFG_XY_W   = 12;

    // Digit counter: base 9, one digit per level
    localparam int               DIGIT_W   = 4;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd8;

    // Heading is kept modulo 36
    localparam int                 HEADING_W     = 6;
    localparam logic [HEADING_W-1:0] HEADING_START = 6'd28;
    localparam logic [HEADING_W-1:0] HEADING_LAST  = 6'd35;

    // Heading turn per old digit value: bit set means +1, clear means -1
    localparam logic [7:0] TURN_PLUS = 8'b1000_1110;

    // Color table, indexed by heading mod 9
    localparam int COLOR_N = 9;
    localparam int COLOR_IDX_W = 4;
    localparam logic [7:0] COL_R [COLOR_N] = '{8'd0, 8'd85, 8'd170, 8'd255, 8'd170,
                                               8'd85, 8'd0, 8'd0, 8'd0};
    localparam logic [7:0] COL_G [COLOR_N] = '{8'd255, 8'd170, 8'd85, 8'd0, 8'd0,
                                               8'd0, 8'd0, 8'd85, 8'd170};
    localparam logic [7:0] COL_B [COLOR_N] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd85,
                                               8'd170, 8'd255, 8'd170, 8'd85};

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_LEVELS   = 2'd0,
        REG_STEP_LEN = 2'd1,
        REG_START_X  = 2'd2,
        REG_START_Y  = 2'd3
    } reg_idx_t;

    // Configuration register set
    typedef struct packed {
        logic [LEVELS_W-1:0] levels;
        logic [STEP_W-1:0]   step_len;
        logic [CFG_XY_W-1:0] start_x;
        logic [CFG_XY_W-1:0] start_y;
    } cfg_t;

    // Carry search result from the digit counter
    typedef struct packed {
        logic last;
        logic turn_plus;
    } dig_status_t;

    // Heading mod 9 for a heading below 36
    function automatic logic [COLOR_IDX_W-1:0] heading_mod9(input logic [HEADING_W-1:0] h);
        logic [HEADING_W-1:0] t;
        t = h;
        if (t >= 6'd27)
        begin
            t = t - 6'd27;
        end
        else if (t >= 6'd18)
        begin
            t = t - 6'd18;
        end
        else if (t >= 6'd9)
        begin
            t = t - 6'd9;
        end
        return t[COLOR_IDX_W-1:0];
    endfunction

endpackage

// File: rtl/peano_curve_segment_generator_top.sv
// ----------------------------------------------------------------------------
// peano_curve_segment_generator_top
// Diagonal Peano curve generator, one line segment per accepted item.
// ----------------------------------------------------------------------------
// Each accepted item yields one segment (from point, to point, color and a
// last-segment flag), registered in the output register. A new item is
// taken every cycle as long as the output register is empty or being read,
// so the sustained rate is one segment per clock. The critical path is the
// carry search over the MAX_LEVELS base-9 digits followed by the heading
// update; the pen update is one COORD_BITS-wide add. Set restart on an item
// to begin the curve at the configured start point; after the last segment
// the next item starts the curve again. Writes to start_x and start_y take
// effect at the next restart or curve end, levels and step_len at once.
// ----------------------------------------------------------------------------
module peano_curve_segment_generator_top #(
    parameter int MAX_LEVELS = pcsg_pkg::MAX_LEVELS_DEF,
    parameter int COORD_BITS = pcsg_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pcsg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pcsg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pcsg_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // Input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            restart,
    // Output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [COORD_BITS-1:0]           from_x,
    output logic [COORD_BITS-1:0]           from_y,
    output logic [COORD_BITS-1:0]           to_x,
    output logic [COORD_BITS-1:0]           to_y,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic                            last_segment
);
    import pcsg_pkg::*;

    cfg_t                  cfg;
    dig_status_t           dig;
    logic                  accept;

    logic [COORD_BITS-1:0] pen_x_reg, pen_x_next;
    logic [COORD_BITS-1:0] pen_y_reg, pen_y_next;
    logic [HEADING_W-1:0]  heading_reg, heading_next;
    logic [COORD_BITS-1:0] start_x_c, start_y_c;
    logic [COORD_BITS-1:0] fx, fy, tx, ty, step_c;
    logic [HEADING_W-1:0]  h_eff, h_turn;
    logic [COLOR_IDX_W-1:0] ci;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] from_x_reg, from_y_reg, to_x_reg, to_y_reg;
    logic [7:0]            red_reg, green_reg, blue_reg;
    logic                  last_reg;

    pcsg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcsg_digit_counter #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_digits (
        .clk     (clk),
        .rst_n   (rst_n),
        .levels  (cfg.levels),
        .restart (restart),
        .advance (accept),
        .status  (dig)
    );

    // Take an item while the output register is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Select pen state, restart returns to the start point
    assign start_x_c = COORD_BITS'(cfg.start_x);
    assign start_y_c = COORD_BITS'(cfg.start_y);
    assign step_c    = COORD_BITS'(cfg.step_len);
    assign fx        = restart ? start_x_c : pen_x_reg;
    assign fy        = restart ? start_y_c : pen_y_reg;
    assign h_eff     = restart ? HEADING_START : heading_reg;

    // Step along the diagonal picked by heading mod 4
    always_comb
    begin
        case (h_eff[1:0])
            2'd0:
            begin
                tx = fx + step_c;
                ty = fy + step_c;
            end
            2'd1:
            begin
                tx = fx + step_c;
                ty = fy - step_c;
            end
            2'd2:
            begin
                tx = fx - step_c;
                ty = fy - step_c;
            end
            default:
            begin
                tx = fx - step_c;
                ty = fy + step_c;
            end
        endcase
    end

    // Turn the heading by one, wrapping modulo 36
    always_comb
    begin
        if (dig.turn_plus)
        begin
            h_turn = (h_eff == HEADING_LAST) ? '0 : h_eff + HEADING_W'(1);
        end
        else
        begin
            h_turn = (h_eff == '0) ? HEADING_LAST : h_eff - HEADING_W'(1);
        end
    end

    assign ci = heading_mod9(h_eff);

    // Curve end goes back to the start, otherwise move the pen
    assign pen_x_next   = dig.last ? start_x_c : tx;
    assign pen_y_next   = dig.last ? start_y_c : ty;
    assign heading_next = dig.last ? HEADING_START : h_turn;

    // Hold pen and heading
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg   <= '0;
            pen_y_reg   <= '0;
            heading_reg <= HEADING_START;
        end
        else if (accept)
        begin
            pen_x_reg   <= pen_x_next;
            pen_y_reg   <= pen_y_next;
            heading_reg <= heading_next;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Load the result item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            from_x_reg <= fx;
            from_y_reg <= fy;
            to_x_reg   <= tx;
            to_y_reg   <= ty;
            red_reg    <= COL_R[ci];
            green_reg  <= COL_G[ci];
            blue_reg   <= COL_B[ci];
            last_reg   <= dig.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign from_x       = from_x_reg;
    assign from_y       = from_y_reg;
    assign to_x         = to_x_reg;
    assign to_y         = to_y_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign last_segment = last_reg;

`ifndef SYNTHESIS
    // A curve end leaves the heading at its start value
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && dig.last |=> heading_reg == HEADING_START)
    else $error("heading not restored after last segment");

    // A plain segment leaves the pen at its end point
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !dig.last |=> pen_x_reg == to_x_reg && pen_y_reg == to_y_reg)
    else $error("pen does not follow segment end");

    // Every accepted item lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg && last_reg == $past(dig.last))
    else $error("accepted item missing from output register");
`endif

endmodule

// File: rtl/pcsg_cfg.sv
// ----------------------------------------------------------------------------
// pcsg_cfg
// APB-style register block: levels, step length and start point.
// ----------------------------------------------------------------------------
module pcsg_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pcsg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pcsg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pcsg_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output pcsg_pkg::cfg_t                  cfg
);
    import pcsg_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Decode writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_LEVELS:   cfg_next.levels   = pwdata[LEVELS_W-1:0];
                REG_STEP_LEN: cfg_next.step_len = pwdata[STEP_W-1:0];
                REG_START_X:  cfg_next.start_x  = pwdata[CFG_XY_W-1:0];
                REG_START_Y:  cfg_next.start_y  = pwdata[CFG_XY_W-1:0];
            endcase
        end
    end

    // Hold register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.levels   <= LEVELS_W'(1);
            cfg_reg.step_len <= STEP_W'(1);
            cfg_reg.start_x  <= '0;
            cfg_reg.start_y  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Decode reads
    always_comb
    begin
        unique case (idx)
            REG_LEVELS:   prdata = APB_DATA_W'(cfg_reg.levels);
            REG_STEP_LEN: prdata = APB_DATA_W'(cfg_reg.step_len);
            REG_START_X:  prdata = APB_DATA_W'(cfg_reg.start_x);
            REG_START_Y:  prdata = APB_DATA_W'(cfg_reg.start_y);
        endcase
    end

endmodule

// File: rtl/pcsg_digit_counter.sv
// ----------------------------------------------------------------------------
// pcsg_digit_counter
// Base-9 digit counter that replaces the curve recursion. Finds the lowest
// digit that is not 8, reports its turn and whether the curve ends here.
// ----------------------------------------------------------------------------
module pcsg_digit_counter #(
    parameter int MAX_LEVELS = pcsg_pkg::MAX_LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pcsg_pkg::LEVELS_W-1:0] levels,
    input  logic                          restart,
    input  logic                          advance,
    output pcsg_pkg::dig_status_t         status
);
    import pcsg_pkg::*;

    logic [DIGIT_W-1:0] digit_reg  [MAX_LEVELS];
    logic [DIGIT_W-1:0] digit_next [MAX_LEVELS];
    logic [DIGIT_W-1:0] base       [MAX_LEVELS];
    logic               carry;
    logic [2:0]         turn_digit;

    // Restart sees a cleared counter
    always_comb
    begin
        for (int k = 0; k < MAX_LEVELS; k++)
        begin
            base[k] = restart ? '0 : digit_reg[k];
        end
    end

    // Carry search: clear the run of 8s, bump the first digit that is not 8
    always_comb
    begin
        carry      = 1'b1;
        turn_digit = '0;
        for (int k = 0; k < MAX_LEVELS; k++)
        begin
            digit_next[k] = base[k];
            if (carry && (k < int'(levels)))
            begin
                if (base[k] == DIGIT_MAX)
                begin
                    digit_next[k] = '0;
                end
                else
                begin
                    turn_digit    = base[k][2:0];
                    digit_next[k] = base[k] + DIGIT_W'(1);
                    carry         = 1'b0;
                end
            end
        end
        // Curve end returns every digit to zero
        if (carry)
        begin
            for (int k = 0; k < MAX_LEVELS; k++)
            begin
                digit_next[k] = '0;
            end
        end
    end

    assign status.last      = carry;
    assign status.turn_plus = TURN_PLUS[turn_digit];

    // Advance the counter on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_LEVELS; k++)
            begin
                digit_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            for (int k = 0; k < MAX_LEVELS; k++)
            begin
                digit_reg[k] <= digit_next[k];
            end
        end
    end

endmodule
